// File: design/bgi_pkg.sv
package bgi_pkg;

  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 64;

  // row pass coefficients fit 36 bits, column pass 40, Horner sums 48
  localparam int ROW_W  = 36;
  localparam int COEF_W = 40;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 64;

  localparam logic [2:0] CFG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] CFG_INV_SPACING_X = 3'd2;
  localparam logic [2:0] CFG_INV_SPACING_Y = 3'd3;
  localparam logic [2:0] CFG_COLS_IN_USE   = 3'd4;
  localparam logic [2:0] CFG_ROWS_IN_USE   = 3'd5;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP,
    S_ADDR,
    S_FETCH,
    S_COLP,
    S_HINIT,
    S_HMUL,
    S_HADD,
    S_GRAD,
    S_RESULT
  } state_t;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef acc_t acc4_t [4];

  // doubled Catmull-Rom coefficients of four equally spaced values
  function automatic acc4_t basis2(input acc_t f0, input acc_t f1, input acc_t f2,
                                   input acc_t f3);
    acc4_t c;
    c[0] = f1 <<< 1;
    c[1] = f2 - f0;
    c[2] = (f0 <<< 1) - (f1 <<< 2) - f1 + (f2 <<< 2) - f3;
    c[3] = f1 + (f1 <<< 1) - f2 - (f2 <<< 1) + f3 - f0;
    return c;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: design/bicubic_grid_interpolator.sv
// Bicubic Catmull-Rom interpolator over a GRID_COLS x GRID_ROWS store of signed Q16.16
// samples. A transaction with tuser = 0 writes one sample (column, row, value); writes
// outside the store are dropped. A transaction with tuser = 1 evaluates at (pos_x, pos_y)
// and returns one result: value, d/dx and d/dy (saturated Q16.16) and an out_of_range
// flag in m_tuser, with zero data when the cell falls outside the interior. An evaluation
// occupies the block through mapping, the sixteen sample reads, the column pass, eleven
// Horner chains and the gradient scaling; when out of range it ends after mapping. All
// products go through one 48x16 multiplier. A finished result waits in the output
// register while the next transaction is accepted. Read a sample only after it was written.
module bicubic_grid_interpolator
  import bgi_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[31:0], pos_y[63:32], sample_col[69:64], sample_row[75:70],
  // sample_value[107:76], zero pad
  input  logic [111:0] s_tdata,
  // func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // interp_value[31:0], grad_x[63:32], grad_y[95:64]
  output logic [95:0]  m_tdata,
  // out_of_range
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = AW + 1;
  localparam int CXW   = $clog2(GRID_COLS);
  localparam int CYW   = $clog2(GRID_ROWS);

  // configuration
  logic [31:0] origin_x, origin_y, inv_spacing_x, inv_spacing_y;
  logic [6:0]  cols_in_use, rows_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inv_spacing_x <= 32'd65536;
      inv_spacing_y <= 32'd65536;
      cols_in_use   <= 7'd64;
      rows_in_use   <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:      origin_x      <= cfg_data;
        CFG_ORIGIN_Y:      origin_y      <= cfg_data;
        CFG_INV_SPACING_X: inv_spacing_x <= cfg_data;
        CFG_INV_SPACING_Y: inv_spacing_y <= cfg_data;
        CFG_COLS_IN_USE:   cols_in_use   <= cfg_data[6:0];
        CFG_ROWS_IN_USE:   rows_in_use   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [31:0] pos_x, pos_y, sample_value;
  logic [5:0]  sample_col, sample_row;
  assign pos_x        = s_tdata[31:0];
  assign pos_y        = s_tdata[63:32];
  assign sample_col   = s_tdata[69:64];
  assign sample_row   = s_tdata[75:70];
  assign sample_value = s_tdata[107:76];

  state_t state, state_next;

  logic        accept;
  logic        mem_we;
  logic [2:0]  step;
  logic [4:0]  fcnt;
  logic [1:0]  pcnt;
  logic [3:0]  chain;
  logic [1:0]  k;

  // shared multiplier
  acc_t                     mul_a;
  logic [15:0]              mul_b;
  logic signed [PROD_W:0]   mul_full;
  logic signed [PROD_W-1:0] prod, acc;

  assign accept   = s_tvalid && s_tready;
  assign mul_full = mul_a * $signed({1'b0, mul_b});

  // mapping
  logic signed [32:0] diff_x, diff_y;
  logic [65:0]        u_now;
  logic [33:0]        ip_now;
  logic [34:0]        eff_x, eff_y, eff_sel;
  logic               axis_ok, ok_x;
  logic [CXW-1:0]     cell_x;
  logic [CYW-1:0]     cell_y;
  logic [15:0]        frac_x, frac_y;
  logic               oor;

  assign u_now  = {2'b00, prod[47:0], 16'h0000} + {18'h0, acc[47:0]};
  assign ip_now = u_now[65:32];
  assign eff_x  = ({28'h0, cols_in_use} > 35'(GRID_COLS)) ? 35'(GRID_COLS)
                                                          : {28'h0, cols_in_use};
  assign eff_y  = ({28'h0, rows_in_use} > 35'(GRID_ROWS)) ? 35'(GRID_ROWS)
                                                          : {28'h0, rows_in_use};
  assign eff_sel = (step == 3'd2) ? eff_x : eff_y;
  assign axis_ok = !((step == 3'd2) ? diff_x[32] : diff_y[32]) && (ip_now != '0) &&
                   ({1'b0, ip_now} + 35'd2 <= eff_sel);

  // grid store
  logic [31:0]   grid [DEPTH];
  logic [31:0]   rd_q;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] wr_full, rd_sum, base_full;
  logic          wr_in_range;

  assign wr_full     = DW'(sample_row) * DW'(GRID_COLS) + DW'(sample_col);
  assign wr_in_range = ({26'h0, sample_row} < 32'(GRID_ROWS)) &&
                       ({26'h0, sample_col} < 32'(GRID_COLS));
  assign rd_sum      = {1'b0, rd_addr} +
                       ((fcnt[1:0] == 2'd3) ? DW'(GRID_COLS - 3) : DW'(1));
  assign base_full   = (DW'(cell_y) - DW'(1)) * DW'(GRID_COLS) + DW'(cell_x) - DW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[wr_full[AW-1:0]] <= sample_value;
    end
    rd_q <= grid[rd_addr];
  end

  // coefficient storage
  logic signed [31:0]       win [3];
  logic signed [ROW_W-1:0]  rowc [4][4];
  logic signed [COEF_W-1:0] a_q [4][4];
  acc_t                     yv [4];
  acc_t                     yd [4];
  acc_t                     h, v_q, dx_q, dy_q;
  logic [31:0]              gx_q, gy_q;
  logic [3:0]               fe;
  acc4_t                    row_b, col_b;

  assign fe    = 4'(fcnt - 5'd1);
  assign row_b = basis2(ACC_W'(win[0]), ACC_W'(win[1]), ACC_W'(win[2]),
                        ACC_W'($signed(rd_q)));
  assign col_b = basis2(ACC_W'(rowc[0][pcnt]), ACC_W'(rowc[1][pcnt]),
                        ACC_W'(rowc[2][pcnt]), ACC_W'(rowc[3][pcnt]));

  // Horner chains: 0..7 run on a[p] along y (even value, odd slope),
  // 8 value and 9 slope along x on yv, 10 value along x on yd
  acc4_t       s_vec;
  logic        deriv, chain_last;
  logic [15:0] t_sel;
  acc_t        add_term, h_new;

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      if (chain < 4'd8) begin
        s_vec[q] = ACC_W'(a_q[chain[2:1]][q]);
      end else if (chain == 4'd10) begin
        s_vec[q] = yd[q];
      end else begin
        s_vec[q] = yv[q];
      end
    end
  end

  assign deriv      = (chain < 4'd8) ? chain[0] : (chain == 4'd9);
  assign t_sel      = (chain < 4'd8) ? frac_y : frac_x;
  assign chain_last = deriv ? (k == 2'd1) : (k == 2'd0);
  assign add_term   = (deriv && k == 2'd2) ? (s_vec[k] <<< 1) : s_vec[k];
  assign h_new      = add_term + acc_t'(prod >>> 16);

  logic signed [PROD_W-1:0] grad_sum;
  assign grad_sum = (prod + acc) >>> 2;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept && s_tuser == FUNC_EVAL) state_next = S_MAP;
      S_MAP:    if (step == 3'd4) state_next = (ok_x && axis_ok) ? S_ADDR : S_RESULT;
      S_ADDR:   state_next = S_FETCH;
      S_FETCH:  if (fcnt == 5'd16) state_next = S_COLP;
      S_COLP:   if (pcnt == 2'd3) state_next = S_HINIT;
      S_HINIT:  state_next = S_HMUL;
      S_HMUL:   state_next = S_HADD;
      S_HADD: begin
        if (chain_last) begin
          state_next = (chain == 4'd10) ? S_GRAD : S_HINIT;
        end else begin
          state_next = S_HMUL;
        end
      end
      S_GRAD:   if (step == 3'd4) state_next = S_RESULT;
      S_RESULT: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    s_tready = 1'b0;
    mem_we   = 1'b0;
    mul_a    = h;
    mul_b    = t_sel;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        mem_we   = s_tvalid && s_tuser == FUNC_WRITE && wr_in_range;
      end
      S_MAP: begin
        mul_a = step[1] ? ACC_W'(diff_y) : ACC_W'(diff_x);
        mul_b = step[1] ? (step[0] ? inv_spacing_y[31:16] : inv_spacing_y[15:0])
                        : (step[0] ? inv_spacing_x[31:16] : inv_spacing_x[15:0]);
      end
      S_GRAD: begin
        mul_a = step[1] ? dy_q : dx_q;
        mul_b = step[1] ? (step[0] ? inv_spacing_y[31:16] : inv_spacing_y[15:0])
                        : (step[0] ? inv_spacing_x[31:16] : inv_spacing_x[15:0]);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      fcnt     <= '0;
      pcnt     <= '0;
      chain    <= '0;
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= (state_next == state && (state == S_MAP || state == S_GRAD)) ?
               3'(step + 3'd1) : 3'd0;
      fcnt  <= (state == S_FETCH) ? 5'(fcnt + 5'd1) : 5'd0;
      pcnt  <= (state == S_COLP) ? 2'(pcnt + 2'd1) : 2'd0;
      if (state == S_COLP) begin
        chain <= '0;
      end else if (state == S_HADD && chain_last) begin
        chain <= 4'(chain + 4'd1);
      end
      if (state == S_HINIT) begin
        k <= 2'd2;
      end else if (state == S_HADD) begin
        k <= 2'(k - 2'd1);
      end
      if (state == S_RESULT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_full[PROD_W-1:0];
    unique case (state)
      S_IDLE: begin
        diff_x <= $signed({pos_x[31], pos_x}) - $signed({origin_x[31], origin_x});
        diff_y <= $signed({pos_y[31], pos_y}) - $signed({origin_y[31], origin_y});
      end
      S_MAP: begin
        if (step == 3'd1 || step == 3'd3) begin
          acc <= prod;
        end
        if (step == 3'd2) begin
          ok_x   <= axis_ok;
          cell_x <= ip_now[CXW-1:0];
          frac_x <= u_now[31:16];
        end
        if (step == 3'd4) begin
          oor    <= !(ok_x && axis_ok);
          cell_y <= ip_now[CYW-1:0];
          frac_y <= u_now[31:16];
        end
      end
      S_ADDR: rd_addr <= base_full[AW-1:0];
      S_FETCH: begin
        if (fcnt != 5'd16) begin
          rd_addr <= (rd_sum >= DW'(DEPTH)) ? AW'(rd_sum - DW'(DEPTH)) : rd_sum[AW-1:0];
        end
        if (fcnt != 5'd0) begin
          win[0] <= win[1];
          win[1] <= win[2];
          win[2] <= $signed(rd_q);
          if (fe[1:0] == 2'd3) begin
            for (int q = 0; q < 4; q++) begin
              rowc[fe[3:2]][q] <= ROW_W'(row_b[q]);
            end
          end
        end
      end
      S_COLP: begin
        for (int q = 0; q < 4; q++) begin
          a_q[pcnt][q] <= COEF_W'(col_b[q]);
        end
      end
      S_HINIT: h <= deriv ? (s_vec[3] + (s_vec[3] <<< 1)) : s_vec[3];
      S_HADD: begin
        h <= h_new;
        if (chain_last) begin
          if (chain < 4'd8) begin
            if (chain[0]) begin
              yd[chain[2:1]] <= h_new;
            end else begin
              yv[chain[2:1]] <= h_new;
            end
          end else if (chain == 4'd8) begin
            v_q <= h_new;
          end else if (chain == 4'd9) begin
            dx_q <= h_new;
          end else begin
            dy_q <= h_new;
          end
        end
      end
      S_GRAD: begin
        if (step == 3'd1 || step == 3'd3) begin
          acc <= prod >>> 16;
        end
        if (step == 3'd2) begin
          gx_q <= sat32(grad_sum);
        end
        if (step == 3'd4) begin
          gy_q <= sat32(grad_sum);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!m_tvalid || m_tready)) begin
      m_tuser <= oor;
      if (oor) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {gy_q, gx_q, sat32(PROD_W'(v_q) >>> 2)};
      end
    end
  end

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("out-of-range result carries nonzero data");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == FUNC_EVAL) |=> !s_tready)
    else $error("ready after accepting an evaluate transaction");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_RESULT))
    else $error("result raised outside the result state");

endmodule
